[rtl/core/rft_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rft_pkg;

    localparam int CHAR_W          = 8;
    localparam int RAIL_W          = 7;
    localparam int LEN_W           = 7;
    localparam int CFG_DATA_W      = 7;
    localparam int CFG_INDEX_W     = 1;
    localparam int MAX_LEN_DEFAULT = 64;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_RAIL_COUNT    = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_DECIPHER_MODE = 1'b1;

    localparam logic [CHAR_W-1:0] SPACE_BYTE       = 8'h20;
    localparam logic [RAIL_W-1:0] RAIL_COUNT_RESET = 7'd3;

    typedef struct packed {
        logic [CHAR_W-1:0] char_in;
        logic              last_in;
    } item_t;

    typedef struct packed {
        logic [CHAR_W-1:0] char_out;
        logic              last_out;
        logic              truncated;
    } result_t;

    // one stored message waiting for the permutation engine
    typedef struct packed {
        logic             bank;
        logic [LEN_W-1:0] len;
        logic [LEN_W-1:0] rails;
        logic             identity;
        logic             decipher;
        logic             overflow;
    } job_t;

endpackage

`default_nettype wire

[rtl/core/rft_store.sv]
`timescale 1ns / 1ps
`default_nettype none

module rft_store #(
    parameter int MAX_LEN = rft_pkg::MAX_LEN_DEFAULT
) (
    input  wire                                  clk,
    input  wire                                  we,
    input  wire  [$clog2(MAX_LEN):0]             waddr,
    input  wire  [rft_pkg::CHAR_W-1:0]           wdata,
    input  wire                                  re,
    input  wire  [$clog2(MAX_LEN):0]             raddr,
    output logic [rft_pkg::CHAR_W-1:0]           rdata
);

    localparam int AW    = $clog2(MAX_LEN);
    localparam int DEPTH = 2 ** (AW + 1);

    // two banks: one fills while the other is read
    logic [rft_pkg::CHAR_W-1:0] text_mem_reg [DEPTH];
    logic [rft_pkg::CHAR_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            text_mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= text_mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[rtl/core/rft_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module rft_front #(
    parameter int MAX_LEN = rft_pkg::MAX_LEN_DEFAULT
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  cfg_we,
    input  wire  [rft_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  wire  [rft_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  wire                                  item_valid,
    output logic                                 item_stall,
    input  rft_pkg::item_t                       item,
    input  wire                                  queue_full,
    output logic                                 push,
    output rft_pkg::job_t                        push_job,
    output logic                                 store_we,
    output logic [$clog2(MAX_LEN):0]             store_addr,
    output logic [rft_pkg::CHAR_W-1:0]           store_data
);

    localparam int AW  = $clog2(MAX_LEN);
    localparam int CW  = $clog2(MAX_LEN + 1);
    localparam int RCW = rft_pkg::RAIL_W + 1;

    logic [rft_pkg::RAIL_W-1:0] rail_count_reg;
    logic                       decipher_reg;
    logic [CW-1:0]              cnt_reg, cnt_next, cnt_after;
    logic                       ovf_reg, ovf_next, ovf_after;
    logic                       bank_reg, bank_next;
    logic                       accept, is_char, room, identity;

    assign item_stall = queue_full;
    assign accept     = item_valid && !queue_full;
    assign is_char    = item.char_in != rft_pkg::SPACE_BYTE;
    assign room       = cnt_reg < CW'(MAX_LEN);

    assign store_we   = accept && is_char && room;
    assign store_addr = {bank_reg, cnt_reg[AW-1:0]};
    assign store_data = item.char_in;

    always_comb
    begin
        cnt_after = cnt_reg + CW'(store_we);
        ovf_after = ovf_reg | (accept && is_char && !room);
        // fewer than two rails, or no rail turn inside the message: order kept
        identity  = (rail_count_reg < rft_pkg::RAIL_W'(2))
                 || ({1'b0, rail_count_reg} >= RCW'(cnt_after));
        push      = accept && item.last_in && (cnt_after != '0);

        push_job.bank     = bank_reg;
        push_job.len      = rft_pkg::LEN_W'(cnt_after);
        push_job.rails    = rft_pkg::LEN_W'(rail_count_reg);
        push_job.identity = identity;
        push_job.decipher = decipher_reg;
        push_job.overflow = ovf_after;

        cnt_next  = cnt_reg;
        ovf_next  = ovf_reg;
        bank_next = bank_reg;
        if (accept)
        begin
            if (item.last_in)
            begin
                cnt_next  = '0;
                ovf_next  = 1'b0;
                bank_next = bank_reg ^ push;
            end
            else
            begin
                cnt_next = cnt_after;
                ovf_next = ovf_after;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rail_count_reg <= rft_pkg::RAIL_COUNT_RESET;
            decipher_reg   <= 1'b0;
            cnt_reg        <= '0;
            ovf_reg        <= 1'b0;
            bank_reg       <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            ovf_reg  <= ovf_next;
            bank_reg <= bank_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    rft_pkg::REG_RAIL_COUNT:    rail_count_reg <= cfg_data;
                    rft_pkg::REG_DECIPHER_MODE: decipher_reg   <= cfg_data[0];
                endcase
            end
        end
    end

endmodule

`default_nettype wire

[rtl/core/rft_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module rft_queue (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 push,
    input  rft_pkg::job_t       push_job,
    input  wire                 pop,
    output rft_pkg::job_t       head,
    output logic                full,
    output logic                empty
);

    rft_pkg::job_t slot_reg [2];
    logic          wr_ptr_reg, rd_ptr_reg;
    logic [1:0]    count_reg;

    assign full  = count_reg == 2'd2;
    assign empty = count_reg == 2'd0;
    assign head  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

`default_nettype wire

[rtl/core/rft_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module rft_back #(
    parameter int MAX_LEN = rft_pkg::MAX_LEN_DEFAULT
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  job_valid,
    input  rft_pkg::job_t                        job,
    output logic                                 pop,
    output logic                                 rd_en,
    output logic [$clog2(MAX_LEN):0]             rd_addr,
    input  wire  [rft_pkg::CHAR_W-1:0]           rd_data,
    output logic                                 result_valid,
    input  wire                                  result_stall,
    output rft_pkg::result_t                     result,
    output logic                                 copy_active,
    output logic                                 copy_bank
);

    localparam int AW = $clog2(MAX_LEN);
    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int SW = $clog2(3 * MAX_LEN);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_COPY  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    state_t                     state_reg, state_next;
    rft_pkg::job_t              job_reg;
    logic [CW-1:0]              k_reg, k_next;
    logic [SW-1:0]              pos_reg, pos_next;
    logic [CW-1:0]              rail_reg, rail_next;
    logic                       phase_reg, phase_next;
    logic                       wr_pend_reg;
    logic [AW-1:0]              dst_reg;

    logic [rft_pkg::CHAR_W-1:0] scratch_reg [2 ** AW];
    logic                       a_valid_reg;
    logic [rft_pkg::CHAR_W-1:0] a_data_reg;
    logic                       a_last_reg, a_trunc_reg;
    logic                       out_valid_reg;
    rft_pkg::result_t           out_reg;

    logic [CW-1:0]              len, rails, rail_inc;
    logic [SW-1:0]              period, rail2, step, sum;
    logic                       edge_rail, k_last;
    logic [AW-1:0]              src, dst;
    logic                       out_ready, a_move, issue;

    // zigzag walker: positions of rail 0 first, each rail in ascending order
    always_comb
    begin
        len       = CW'(job_reg.len);
        rails     = CW'(job_reg.rails);
        rail_inc  = rail_reg + CW'(1);
        period    = SW'({rails, 1'b0}) - SW'(2);
        rail2     = SW'({rail_reg, 1'b0});
        edge_rail = (rail_reg == '0) || (rail_reg == rails - CW'(1));
        if (job_reg.identity)
        begin
            step = SW'(1);
        end
        else if (edge_rail)
        begin
            step = period;
        end
        else if (phase_reg)
        begin
            step = rail2;
        end
        else
        begin
            step = period - rail2;
        end
        sum    = pos_reg + step;
        k_last = (k_reg + CW'(1)) == len;
        src    = job_reg.decipher ? k_reg[AW-1:0]   : pos_reg[AW-1:0];
        dst    = job_reg.decipher ? pos_reg[AW-1:0] : k_reg[AW-1:0];
    end

    assign out_ready = !out_valid_reg || !result_stall;
    assign a_move    = a_valid_reg && out_ready;
    assign issue     = (state_reg == ST_EMIT) && (!a_valid_reg || out_ready);

    assign pop         = state_reg == ST_DRAIN;
    assign rd_en       = state_reg == ST_COPY;
    assign rd_addr     = {job_reg.bank, src};
    assign copy_active = state_reg == ST_COPY;
    assign copy_bank   = job_reg.bank;

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        pos_next   = pos_reg;
        rail_next  = rail_reg;
        phase_next = phase_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    state_next = ST_COPY;
                    k_next     = '0;
                    pos_next   = '0;
                    rail_next  = '0;
                    phase_next = 1'b0;
                end
            end
            ST_COPY:
            begin
                if (k_last)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    k_next = k_reg + CW'(1);
                    if (!job_reg.identity && (sum >= SW'(len)))
                    begin
                        rail_next  = rail_inc;
                        pos_next   = SW'(rail_inc);
                        phase_next = 1'b0;
                    end
                    else
                    begin
                        pos_next   = sum;
                        phase_next = ~phase_reg;
                    end
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_EMIT;
                k_next     = '0;
            end
            ST_EMIT:
            begin
                if (issue)
                begin
                    if (k_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        k_next = k_reg + CW'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            job_reg       <= '0;
            k_reg         <= '0;
            pos_reg       <= '0;
            rail_reg      <= '0;
            phase_reg     <= 1'b0;
            wr_pend_reg   <= 1'b0;
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            k_reg       <= k_next;
            pos_reg     <= pos_next;
            rail_reg    <= rail_next;
            phase_reg   <= phase_next;
            wr_pend_reg <= state_reg == ST_COPY;
            if ((state_reg == ST_IDLE) && job_valid)
            begin
                job_reg <= job;
            end
            if (issue)
            begin
                a_valid_reg <= 1'b1;
            end
            else if (a_move)
            begin
                a_valid_reg <= 1'b0;
            end
            if (a_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // scratch buffer, emit stage and output register
    always_ff @(posedge clk)
    begin
        dst_reg <= dst;
        if (wr_pend_reg)
        begin
            scratch_reg[dst_reg] <= rd_data;
        end
        if (issue)
        begin
            a_data_reg  <= scratch_reg[k_reg[AW-1:0]];
            a_last_reg  <= k_last;
            a_trunc_reg <= job_reg.overflow;
        end
        if (a_move)
        begin
            out_reg.char_out  <= a_data_reg;
            out_reg.last_out  <= a_last_reg;
            out_reg.truncated <= a_trunc_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

`default_nettype wire

[rtl/core/rail_fence_transposer.sv]
// Rail-fence transposer: collects a message, emits it permuted over a zigzag.
// Throughput: one byte per cycle on load while the job queue is not full; the back
//   end copies each message through the store read port, then emits it, one result
//   per cycle while result_stall is low.
// Reset: control cleared, rail count 3, encipher mode; the text store is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module rail_fence_transposer #(
    parameter int MAX_LEN = rft_pkg::MAX_LEN_DEFAULT
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  cfg_we,
    input  wire  [rft_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  wire  [rft_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  wire                                  item_valid,
    output logic                                 item_stall,
    input  rft_pkg::item_t                       item,
    output logic                                 result_valid,
    input  wire                                  result_stall,
    output rft_pkg::result_t                     result
);

    localparam int AW = $clog2(MAX_LEN);

    // Front end: drops spaces, fills the free bank of the text store and, at the end
    // of a non-empty message, hands on a job (bank, length, rails, mode, overflow).
    logic                       push, pop, q_full, q_empty;
    rft_pkg::job_t              push_job, head_job;
    logic                       store_we;
    logic [AW:0]                store_addr;
    logic [rft_pkg::CHAR_W-1:0] store_data;

    // Back end read side of the store
    logic                       rd_en;
    logic [AW:0]                rd_addr;
    logic [rft_pkg::CHAR_W-1:0] rd_data;
    logic                       copy_active, copy_bank;

    rft_front #(
        .MAX_LEN (MAX_LEN)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .queue_full (q_full),
        .push       (push),
        .push_job   (push_job),
        .store_we   (store_we),
        .store_addr (store_addr),
        .store_data (store_data)
    );

    // Two-entry job queue; an entry holds its bank until the copy pass ends,
    // so a full queue means both banks are taken and input transfers stall.
    rft_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head_job),
        .full     (q_full),
        .empty    (q_empty)
    );

    rft_store #(
        .MAX_LEN (MAX_LEN)
    ) u_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (store_addr),
        .wdata (store_data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // Back end: copy pass permutes the bank into a scratch buffer, the emit
    // pass streams it out through a two-stage pipeline under result_stall.
    rft_back #(
        .MAX_LEN (MAX_LEN)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (!q_empty),
        .job          (head_job),
        .pop          (pop),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .copy_active  (copy_active),
        .copy_bank    (copy_bank)
    );

    // Checks
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && q_full))
        else $error("job pushed into a full queue");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && q_empty))
        else $error("job popped from an empty queue");

    a_bank_apart: assert property (@(posedge clk) disable iff (!rst_n)
        (store_we && copy_active) |-> (store_addr[AW] != copy_bank))
        else $error("front end writes the bank under copy");

endmodule

`default_nettype wire

[test/tb.sv]
`timescale 1ns / 1ps

module tb;

    import rft_pkg::*;

    localparam int MSG_CAP     = MAX_LEN_DEFAULT;
    // Generous limit for the slowest legal run.
    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_WAIT  = 2 * MSG_CAP + 40;
    localparam int HOLD_CYCLES = 700;
    localparam int PHASE_ITEMS = 28;

    // ------------------------------------------------------------------
    // Predictor and store of due burst bytes
    // ------------------------------------------------------------------
    class zigzag_scoreboard;
        logic [CHAR_W-1:0] text[MSG_CAP];
        int unsigned       count;
        bit                overflow;
        int unsigned       rails;
        bit                decipher;
        result_t           due[$];
        int unsigned       errors;
        int unsigned       messages;
        int unsigned       empties;
        int unsigned       truncs;
        int unsigned       bytes_checked;

        function new();
            count    = 0;
            overflow = 0;
            rails    = RAIL_COUNT_RESET;
            decipher = 1'b0;
            errors   = 0;
            messages = 0;
            empties  = 0;
            truncs   = 0;
            bytes_checked = 0;
        endfunction

        function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_RAIL_COUNT)
                rails = data;
            else if (idx == REG_DECIPHER_MODE)
                decipher = data[0];
        endfunction

        // Called for every accepted input transfer.
        function void take_byte(item_t it);
            int unsigned       order[MSG_CAP];
            logic [CHAR_W-1:0] permuted[MSG_CAP];
            int unsigned       n, k, r, i, per, m, rail;
            result_t           res;
            if (it.char_in != SPACE_BYTE)
            begin
                if (count < MSG_CAP)
                begin
                    text[count] = it.char_in;
                    count++;
                end
                else
                    overflow = 1'b1;
            end
            if (!it.last_in)
                return;
            n = count;
            messages++;
            if (n == 0)
                empties++;
            else if (overflow)
                truncs++;
            k = 0;
            if (rails < 2)
            begin
                for (i = 0; i < n; i++)
                    order[i] = i;
            end
            else
            begin
                per = 2 * (rails - 1);
                for (r = 0; r < rails && k < n; r++)
                    for (i = 0; i < n; i++)
                    begin
                        m    = i % per;
                        rail = (m < rails) ? m : per - m;
                        if (rail == r)
                        begin
                            order[k] = i;
                            k++;
                        end
                    end
            end
            for (k = 0; k < n; k++)
            begin
                if (decipher)
                    permuted[order[k]] = text[k];
                else
                    permuted[k] = text[order[k]];
            end
            for (k = 0; k < n; k++)
            begin
                res.char_out  = permuted[k];
                res.last_out  = (k + 1 == n);
                res.truncated = overflow;
                due.insert(due.size(), res);
            end
            count    = 0;
            overflow = 1'b0;
        endfunction

        // Called for every accepted output transfer.
        function void match_output(result_t got);
            result_t want;
            if (due.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got char %h last %b trunc %b",
                         $time, got.char_out, got.last_out, got.truncated);
                errors++;
                return;
            end
            want = due.pop_front();
            bytes_checked++;
            if (got.char_out !== want.char_out)
            begin
                $display("%0t: char_out expected %h got %h", $time, want.char_out, got.char_out);
                errors++;
            end
            if (got.last_out !== want.last_out)
            begin
                $display("%0t: last_out expected %b got %b", $time, want.last_out, got.last_out);
                errors++;
            end
            if (got.truncated !== want.truncated)
            begin
                $display("%0t: truncated expected %b got %b",
                         $time, want.truncated, got.truncated);
                errors++;
            end
        endfunction

        function int pending();
            return due.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Block and its ports
    // ------------------------------------------------------------------
    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   item_valid;
    logic                   item_stall;
    item_t                  item;
    logic                   result_valid;
    logic                   result_stall;
    result_t                result;

    rail_fence_transposer i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    zigzag_scoreboard zigzag;

    logic [CHAR_W-1:0] msg_bytes[$];   // message being offered, last byte last
    int                burst_left  = 0;
    int                phase_items = 0; // input transfers in the current phase
    int                settings    = 1;
    bit                long_hold_req = 1'b0;
    bit                input_held  = 1'b0; // input seen stalled in the current phase
    int                cycle_count = 0;

    // 12 ns clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Output monitor. Stall is driven by NBA, so the value read here is the
    // one the block saw at this edge.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            zigzag.match_output(result);
    end

    // ------------------------------------------------------------------
    // Receiver: stretches of free flow, random stall and a fixed pattern,
    // plus one long hold-off on request so the block backs up into its input.
    // ------------------------------------------------------------------
    initial
    begin
        int mode;
        int span;
        result_stall <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                mode = $urandom_range(0, 2);
                span = $urandom_range(10, 80);
                for (int k = 0; k < span; k++)
                begin
                    case (mode)
                        0:       result_stall <= 1'b0;
                        1:       result_stall <= 1'($urandom_range(0, 1));
                        default: result_stall <= (k % 3 == 0);
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------

    // One input transfer. Valid stays high between transfers of a burst; it
    // is lowered only when a gap starts or in wait_idle, so it never gets two NBAs in a step.
    task automatic send_byte(logic [CHAR_W-1:0] c, logic l);
        item_t word;
        int    gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 12);
            if (gap > 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        word.char_in = c;
        word.last_in = l;
        item_valid <= 1'b1;
        item       <= word;
        @(posedge clk);
        while (item_stall)
        begin
            input_held = 1'b1;
            @(posedge clk);
        end
        zigzag.take_byte(word);
        phase_items++;
        burst_left--;
    endtask

    task automatic send_message();
        for (int i = 0; i < msg_bytes.size(); i++)
            send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
    endtask

    // Mostly short messages; now and then one long enough to fill or overrun
    // the store, and now and then a lone space that yields no burst at all.
    task automatic random_message(bit short_only);
        int len;
        msg_bytes.delete();
        if ($urandom_range(0, 15) == 0)
            len = 1;
        else if (!short_only && $urandom_range(0, 6) == 0)
            len = $urandom_range(MSG_CAP - 2, MSG_CAP + 16);
        else
            len = $urandom_range(1, 14);
        for (int i = 0; i < len; i++)
        begin
            if (len == 1 && $urandom_range(0, 1) == 0)
                msg_bytes.insert(msg_bytes.size(), SPACE_BYTE);
            else if ($urandom_range(0, 5) == 0)
                msg_bytes.insert(msg_bytes.size(), SPACE_BYTE);
            else
                msg_bytes.insert(msg_bytes.size(), CHAR_W'($urandom_range(0, 255)));
        end
        send_message();
    endtask

    // Drop valid, wait until every due byte has arrived, then give the back
    // end time to finish any message that produces nothing.
    task automatic wait_idle();
        item_valid <= 1'b0;
        burst_left = 0;
        while (zigzag.pending() > 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        zigzag.set_reg(idx, data);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int rail_set[6];
        bit mode_set[6];
        zigzag = new();
        rst_n      <= 1'b0;
        cfg_we     <= 1'b0;
        cfg_index  <= REG_RAIL_COUNT;
        cfg_data   <= '0;
        item_valid <= 1'b0;
        item       <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed messages at the reset setting (3 rails, encipher).
        // Byte extremes with a space in the middle.
        msg_bytes = '{8'h00, 8'hFF, SPACE_BYTE, 8'h41, 8'h7F, 8'h80, 8'h42};
        send_message();
        // Lone space marked last: nothing stored, no burst.
        msg_bytes = '{SPACE_BYTE};
        send_message();
        // Single byte.
        msg_bytes = '{8'h5A};
        send_message();
        // Last transfer is a space; spaces scattered through.
        msg_bytes = '{SPACE_BYTE, 8'h31, SPACE_BYTE, 8'h32, 8'h33, 8'h34, SPACE_BYTE};
        send_message();
        // Length equal to rail count: zigzag only goes down, so identity.
        msg_bytes = '{8'h41, 8'h42, 8'h43};
        send_message();
        wait_idle();

        // Random phases: both extremes of the rail count in each mode, then
        // random settings. The decipher write carries junk in the upper bits.
        rail_set = '{2, 64, 2, 64, 0, 0};
        mode_set = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1};
        for (int p = 0; p < 6; p++)
        begin
            if (p >= 4)
            begin
                rail_set[p] = $urandom_range(2, 64);
                if (p == 4)
                    mode_set[p] = 1'($urandom_range(0, 1));
            end
            write_reg(REG_RAIL_COUNT, CFG_DATA_W'(rail_set[p]));
            write_reg(REG_DECIPHER_MODE, {6'($urandom_range(0, 63)), mode_set[p]});
            cfg_we <= 1'b0;
            settings++;
            input_held = 1'b0;
            // Second phase: receiver holds off while short messages keep
            // coming, so the block fills up and stalls its input. The phase
            // only starts once the hold-off is under way.
            if (p == 1)
            begin
                long_hold_req = 1'b1;
                wait (!long_hold_req);
            end
            phase_items = 0;
            while (phase_items < PHASE_ITEMS || (p == 1 && !input_held))
                random_message(p == 1);
            wait_idle();
        end

        $display("Ran %0d messages over %0d settings: %0d truncated, %0d empty.",
                 zigzag.messages, settings, zigzag.truncs, zigzag.empties);
        $display("Checked %0d burst bytes, %0d mismatches.",
                 zigzag.bytes_checked, zigzag.errors);
        if (zigzag.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
